// File: hw/rtl/ctab_pkg.sv
// shared types, codes and sizes for the connection table block
`timescale 1ns / 1ps
`default_nettype none

package ctab_pkg;

    // table size and derived index width
    localparam int CONNECTIONS = 8;
    localparam int IDX_W       = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

    // field widths fixed by the interface
    localparam int PORT_W   = 16;
    localparam int ID_W     = 3;
    localparam int SEG_W    = 3;
    localparam int STATUS_W = 2;
    localparam int STATE_W  = 2;
    localparam int TICK_W   = 16;

    // timeout after reset
    localparam logic [TICK_W-1:0] FIN_TIMEOUT_RST = TICK_W'(100);

    // command codes carried on the input tuser
    typedef enum logic [2:0] {
        CMD_OPEN    = 3'd0,
        CMD_ACCEPT  = 3'd1,
        CMD_CLOSE   = 3'd2,
        CMD_SEGMENT = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    // segment types
    localparam logic [SEG_W-1:0] SEG_SYN    = 3'd0;
    localparam logic [SEG_W-1:0] SEG_SYNACK = 3'd1;
    localparam logic [SEG_W-1:0] SEG_FIN    = 3'd2;
    localparam logic [SEG_W-1:0] SEG_FINACK = 3'd3;
    localparam logic [SEG_W-1:0] SEG_NONE   = 3'd0;

    // handshake state of one entry
    typedef enum logic [STATE_W-1:0] {
        CS_CLOSED    = 2'd0,
        CS_LISTENING = 2'd1,
        CS_CONNECTED = 2'd2,
        CS_CLOSEWAIT = 2'd3
    } conn_state_t;

    // result status codes
    localparam logic [STATUS_W-1:0] RS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] RS_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] RS_DROPPED = 2'd2;

    // controller states
    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } ctl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic exec;
    } ctab_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_stall;
    } ctab_sts_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     entry_index;
        conn_state_t         conn_state;
        logic                send_valid;
        logic [SEG_W-1:0]    send_type;
        logic [PORT_W-1:0]   send_src_port;
        logic [PORT_W-1:0]   send_dest_port;
    } ctab_res_t;

    // entry index to the 3-bit result field
    function automatic logic [ID_W-1:0] idx_to_id(input logic [IDX_W-1:0] idx);
        logic [IDX_W+ID_W-1:0] ext;
        ext = {{ID_W{1'b0}}, idx};
        return ext[ID_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/connection_table_handshake_fsm_top.sv
// top level of the server connection table with handshake state machine
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Commands enter on the s_ stream (cmd on s_tuser, other fields on s_tdata);
// each accepted transfer produces exactly one result transfer on the m_
// stream (send_valid on m_tuser, other fields on m_tdata).
// The close-wait timeout is written through cfg_valid/cfg_data; cfg_ready is
// always high, and writes are meant to happen while the block is idle.
// Operation: a command is captured on its input transfer and executed in
// the controller's execute state, when the 8-entry port compare, entry update
// and result register load happen together; the result is then offered from
// the output register. A new command is accepted only after the previous one
// has executed, set by the capture/execute sequence of the controller.
// The next command is accepted while a result still waits in the output
// register; a stalled receiver holds that result and blocks execution of the
// following command until the transfer completes.
// Reset (aresetn low, synchronous) frees every entry, sets all entries closed
// with stopped timers, drops any pending result and loads a timeout of 100.

module connection_table_handshake_fsm_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] socket_id, [18:3] port_number, [21:19] seg_type,
    // [37:22] seg_src_port, [53:38] seg_dest_port
    input  wire logic [55:0] s_tdata,
    // [2:0] cmd
    input  wire logic [2:0]  s_tuser,
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [4:2] entry_index, [6:5] conn_state, [9:7] send_type,
    // [25:10] send_src_port, [41:26] send_dest_port
    output logic [47:0]      m_tdata,
    // [0] send_valid
    output logic [0:0]       m_tuser,
    // timeout register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import ctab_pkg::*;

    ctab_cmd_t ctl_cmd;
    ctab_sts_t dp_sts;
    ctab_res_t res;
    logic      res_valid;

    assign cfg_ready = 1'b1;

    // controller
    ctab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    // datapath
    ctab_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (ctl_cmd),
        .sts              (dp_sts),
        .in_cmd           (s_tuser),
        .in_socket_id     (s_tdata[2:0]),
        .in_port_number   (s_tdata[18:3]),
        .in_seg_type      (s_tdata[21:19]),
        .in_seg_src_port  (s_tdata[37:22]),
        .in_seg_dest_port (s_tdata[53:38]),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .m_tready         (m_tready),
        .m_valid          (res_valid),
        .m_res            (res)
    );

    // result packing
    assign m_tvalid = res_valid;
    assign m_tdata  = {6'b0, res.send_dest_port, res.send_src_port, res.send_type,
                       res.conn_state, res.entry_index, res.status};
    assign m_tuser  = res.send_valid;

endmodule

`default_nettype wire

// File: hw/rtl/ctab_ctrl.sv
// controller state machine: sequences input capture and execution
`timescale 1ns / 1ps
`default_nettype none

module ctab_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire ctab_pkg::ctab_sts_t sts,
    output ctab_pkg::ctab_cmd_t     cmd
);
    import ctab_pkg::*;

    ctl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.latch_in = 1'b0;
        cmd.exec     = 1'b0;
        unique case (state_reg)
            CTL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = CTL_EXEC;
                end
            end
            CTL_EXEC: begin
                // wait while the output register still holds an untaken result
                if (!sts.out_stall) begin
                    cmd.exec   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/ctab_dp.sv
// datapath: connection table, port lookup, entry update and result register
`timescale 1ns / 1ps
`default_nettype none

module ctab_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ctab_pkg::ctab_cmd_t             cmd,
    output ctab_pkg::ctab_sts_t                  sts,
    input  wire logic [2:0]                      in_cmd,
    input  wire logic [ctab_pkg::ID_W-1:0]       in_socket_id,
    input  wire logic [ctab_pkg::PORT_W-1:0]     in_port_number,
    input  wire logic [ctab_pkg::SEG_W-1:0]      in_seg_type,
    input  wire logic [ctab_pkg::PORT_W-1:0]     in_seg_src_port,
    input  wire logic [ctab_pkg::PORT_W-1:0]     in_seg_dest_port,
    input  wire logic                            cfg_we,
    input  wire logic [ctab_pkg::TICK_W-1:0]     cfg_data,
    input  wire logic                            m_tready,
    output logic                                 m_valid,
    output ctab_pkg::ctab_res_t                  m_res
);
    import ctab_pkg::*;

    // captured input item
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   sid_reg;
    logic [PORT_W-1:0] port_reg;
    logic [SEG_W-1:0]  stype_reg;
    logic [PORT_W-1:0] src_reg;
    logic [PORT_W-1:0] dst_reg;

    // configuration
    logic [TICK_W-1:0] fin_timeout_reg;

    // table
    logic              used_reg  [CONNECTIONS];
    conn_state_t       fsm_reg   [CONNECTIONS];
    logic [TICK_W-1:0] cnt_reg   [CONNECTIONS];
    logic [PORT_W-1:0] lport_reg [CONNECTIONS];
    logic [PORT_W-1:0] cport_reg [CONNECTIONS];

    logic              used_next [CONNECTIONS];
    conn_state_t       fsm_next  [CONNECTIONS];
    logic [TICK_W-1:0] cnt_next  [CONNECTIONS];

    // result register
    logic      m_valid_reg;
    ctab_res_t res_reg, res_next;

    // lookup
    logic [PORT_W-1:0]   cmp_port;
    logic [CONNECTIONS-1:0] match_vec;
    logic [CONNECTIONS-1:0] free_vec;
    logic                hit_any;
    logic                free_any;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W+ID_W-1:0] sid_ext;
    logic                sid_in_range;
    logic [IDX_W-1:0]    sid_idx;
    logic [IDX_W-1:0]    rd_idx;
    logic                rd_used;
    conn_state_t         rd_fsm;
    logic [PORT_W-1:0]   rd_lport;
    logic [PORT_W-1:0]   rd_cport;
    logic [TICK_W-1:0]   timeout_val;

    // single-entry update controls
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_used;
    conn_state_t       wr_fsm;
    logic              wr_cnt_en;
    logic [TICK_W-1:0] wr_cnt;
    logic              wr_lport_en;
    logic              wr_cport_en;
    logic              do_tick;

    logic [CONNECTIONS-1:0] cw_zero;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg   <= cmd_t'(in_cmd);
            sid_reg   <= in_socket_id;
            port_reg  <= in_port_number;
            stype_reg <= in_seg_type;
            src_reg   <= in_seg_src_port;
            dst_reg   <= in_seg_dest_port;
        end
    end

    // timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_timeout_reg <= FIN_TIMEOUT_RST;
        end else if (cfg_we) begin
            fin_timeout_reg <= cfg_data;
        end
    end

    assign timeout_val = (fin_timeout_reg == '0) ? TICK_W'(1) : fin_timeout_reg;

    // parallel port compare over all entries
    assign cmp_port = (cmd_reg == CMD_OPEN) ? port_reg : dst_reg;

    always_comb begin
        for (int i = 0; i < CONNECTIONS; i++) begin
            match_vec[i] = used_reg[i] && (lport_reg[i] == cmp_port);
            free_vec[i]  = !used_reg[i];
        end
    end

    // lowest matching and lowest free entry
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CONNECTIONS - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any  = |match_vec;
    assign free_any = |free_vec;

    // addressed entry
    assign sid_ext      = {{IDX_W{1'b0}}, sid_reg};
    assign sid_in_range = (sid_ext < CONNECTIONS);
    assign sid_idx      = sid_ext[IDX_W-1:0];
    assign rd_idx       = (cmd_reg == CMD_SEGMENT) ? hit_idx : sid_idx;
    assign rd_used      = used_reg[rd_idx];
    assign rd_fsm       = fsm_reg[rd_idx];
    assign rd_lport     = lport_reg[rd_idx];
    assign rd_cport     = cport_reg[rd_idx];

    // command decode: result and entry update
    always_comb begin
        res_next                = '0;
        res_next.conn_state     = CS_CLOSED;
        wr_en       = 1'b0;
        wr_idx      = rd_idx;
        wr_used     = rd_used;
        wr_fsm      = rd_fsm;
        wr_cnt_en   = 1'b0;
        wr_cnt      = '0;
        wr_lport_en = 1'b0;
        wr_cport_en = 1'b0;
        do_tick     = 1'b0;
        unique case (cmd_reg) inside
            CMD_OPEN: begin
                res_next.status = RS_REFUSED;
                if (!hit_any && free_any) begin
                    res_next.status      = RS_OK;
                    res_next.entry_index = idx_to_id(free_idx);
                    wr_en       = 1'b1;
                    wr_idx      = free_idx;
                    wr_used     = 1'b1;
                    wr_fsm      = CS_CLOSED;
                    wr_cnt_en   = 1'b1;
                    wr_lport_en = 1'b1;
                end
            end
            CMD_ACCEPT, CMD_CLOSE, CMD_QUERY: begin
                if (!(sid_in_range && rd_used)) begin
                    res_next.status = RS_REFUSED;
                end else if (cmd_reg == CMD_QUERY) begin
                    res_next.conn_state = rd_fsm;
                end else if (rd_fsm != CS_CLOSED) begin
                    res_next.status     = RS_REFUSED;
                    res_next.conn_state = rd_fsm;
                end else if (cmd_reg == CMD_ACCEPT) begin
                    res_next.conn_state = CS_LISTENING;
                    wr_en  = 1'b1;
                    wr_fsm = CS_LISTENING;
                end else begin
                    wr_en     = 1'b1;
                    wr_used   = 1'b0;
                    wr_fsm    = CS_CLOSED;
                    wr_cnt_en = 1'b1;
                end
            end
            CMD_SEGMENT: begin
                res_next.status = RS_DROPPED;
                if (hit_any) begin
                    res_next.entry_index = idx_to_id(hit_idx);
                    res_next.conn_state  = rd_fsm;
                    if (stype_reg == SEG_SYN &&
                        (rd_fsm == CS_LISTENING || rd_fsm == CS_CONNECTED)) begin
                        // client port is taken only on the first syn
                        wr_en       = 1'b1;
                        wr_fsm      = CS_CONNECTED;
                        wr_cport_en = (rd_fsm == CS_LISTENING);
                        res_next.status         = RS_OK;
                        res_next.conn_state     = CS_CONNECTED;
                        res_next.send_valid     = 1'b1;
                        res_next.send_type      = SEG_SYNACK;
                        res_next.send_src_port  = rd_lport;
                        res_next.send_dest_port = (rd_fsm == CS_LISTENING) ? src_reg
                                                                           : rd_cport;
                    end else if (stype_reg == SEG_FIN &&
                        (rd_fsm == CS_CONNECTED || rd_fsm == CS_CLOSEWAIT)) begin
                        // fin restarts the close-wait timer
                        wr_en     = 1'b1;
                        wr_fsm    = CS_CLOSEWAIT;
                        wr_cnt_en = 1'b1;
                        wr_cnt    = timeout_val;
                        res_next.status         = RS_OK;
                        res_next.conn_state     = CS_CLOSEWAIT;
                        res_next.send_valid     = 1'b1;
                        res_next.send_type      = SEG_FINACK;
                        res_next.send_src_port  = rd_lport;
                        res_next.send_dest_port = rd_cport;
                    end
                end
            end
            CMD_TICK: begin
                do_tick = 1'b1;
            end
            default: begin
                res_next.status = RS_REFUSED;
            end
        endcase
    end

    // next table state: one addressed write or a countdown in every lane
    always_comb begin
        for (int i = 0; i < CONNECTIONS; i++) begin
            used_next[i] = used_reg[i];
            fsm_next[i]  = fsm_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (cmd.exec) begin
                if (do_tick) begin
                    if (used_reg[i] && cnt_reg[i] != '0) begin
                        cnt_next[i] = cnt_reg[i] - TICK_W'(1);
                        if (cnt_reg[i] == TICK_W'(1) && fsm_reg[i] == CS_CLOSEWAIT) begin
                            fsm_next[i] = CS_CLOSED;
                        end
                    end
                end else if (wr_en && wr_idx == IDX_W'(i)) begin
                    used_next[i] = wr_used;
                    fsm_next[i]  = wr_fsm;
                    if (wr_cnt_en) begin
                        cnt_next[i] = wr_cnt;
                    end
                end
            end
        end
    end

    // table control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CONNECTIONS; i++) begin
                used_reg[i] <= 1'b0;
                fsm_reg[i]  <= CS_CLOSED;
                cnt_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < CONNECTIONS; i++) begin
                used_reg[i] <= used_next[i];
                fsm_reg[i]  <= fsm_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
        end
    end

    // port storage, written only on open and first syn
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_lport_en) begin
            lport_reg[wr_idx] <= port_reg;
        end
        if (cmd.exec && wr_cport_en) begin
            cport_reg[wr_idx] <= src_reg;
        end
    end

    // result register and its valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_res         = res_reg;
    assign sts.out_stall = m_valid_reg && !m_tready;

    // close-wait entries always have a running timer
    always_comb begin
        for (int i = 0; i < CONNECTIONS; i++) begin
            cw_zero[i] = (fsm_reg[i] == CS_CLOSEWAIT) && (cnt_reg[i] == '0);
        end
    end

    a_cw_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        cw_zero == '0)
        else $error("close-wait entry with expired timer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !(m_valid_reg && !m_tready))
        else $error("result register overwritten before transfer");

    a_reply_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.send_valid |-> res_reg.status == RS_OK)
        else $error("reply segment with failing status");

    a_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && cmd_reg == CMD_TICK |=> res_reg == '0)
        else $error("tick result not all zero");

endmodule

`default_nettype wire
